// ===== rtl/core/fpap_pkg.sv =====
`default_nettype none

package fpap_pkg;

	// character codes
	localparam logic [7:0] CHAR_END    = 8'h00;
	localparam logic [7:0] CHAR_COMMA  = 8'h2c;
	localparam logic [7:0] CHAR_PERIOD = 8'h2e;
	localparam logic [7:0] CHAR_DIGIT0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT9 = 8'h39;

	localparam logic [11:0] OCTET_MAX   = 12'd255;
	localparam logic [1:0]  LAST_OCTET  = 2'd3;
	localparam logic [2:0]  ADDR_COMMAS = 3'd4;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_TAIL = 2'd3
	} phase_t;

	// one finished parse
	typedef struct packed {
		logic        accepted;
		logic [31:0] host_address;
		logic [15:0] port_number;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[CHAR_DIGIT0:CHAR_DIGIT9]});
	endfunction

	// value * 10 + digit, kept 12 bits wide so overflow past 255 is visible
	function automatic logic [11:0] times_ten_add(input logic [7:0] value,
		input logic [7:0] c);
		logic [7:0] digit;
		digit = c - CHAR_DIGIT0;
		return {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {8'h00, digit[3:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpap_parse_state.sv =====
`default_nettype none

module fpap_parse_state
	import fpap_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_in,
	output result_t         result
);

	phase_t      phase_q, phase_d;
	logic [2:0]  comma_count_q, comma_count_d;
	logic [1:0]  octet_index_q, octet_index_d;
	logic [7:0]  octet_value_q, octet_value_d;
	logic        too_big_q, too_big_d;
	logic        digit_seen_q, digit_seen_d;
	logic        addr_fail_q, addr_fail_d;
	logic        addr_done_q, addr_done_d;
	logic [31:0] addr_word_q, addr_word_d;
	logic [7:0]  port_high_q, port_high_d;
	logic [7:0]  port_low_q, port_low_d;

	logic        digit;
	logic [11:0] octet_next;
	logic [11:0] high_next;
	logic [11:0] low_next;
	logic        close_fail;
	logic [2:0]  comma_inc;
	logic        ok;

	assign digit      = is_digit(char_in);
	assign octet_next = times_ten_add(octet_value_q, char_in);
	assign high_next  = times_ten_add(port_high_q, char_in);
	assign low_next   = times_ten_add(port_low_q, char_in);
	assign close_fail = addr_fail_q | ~digit_seen_q | too_big_q;
	assign comma_inc  = comma_count_q + 3'd1;

	always_comb begin
		phase_d       = phase_q;
		comma_count_d = comma_count_q;
		octet_index_d = octet_index_q;
		octet_value_d = octet_value_q;
		too_big_d     = too_big_q;
		digit_seen_d  = digit_seen_q;
		addr_fail_d   = addr_fail_q;
		addr_done_d   = addr_done_q;
		addr_word_d   = addr_word_q;
		port_high_d   = port_high_q;
		port_low_d    = port_low_q;
		if (char_in == CHAR_END) begin
			phase_d       = PH_ADDR;
			comma_count_d = '0;
			octet_index_d = '0;
			octet_value_d = '0;
			too_big_d     = 1'b0;
			digit_seen_d  = 1'b0;
			addr_fail_d   = 1'b0;
			addr_done_d   = 1'b0;
			addr_word_d   = '0;
			port_high_d   = '0;
			port_low_d    = '0;
		end else begin
			case (phase_q)
				PH_ADDR: begin
					if (!addr_fail_q && !addr_done_q) begin
						if (digit) begin
							too_big_d     = too_big_q | (octet_next > OCTET_MAX);
							octet_value_d = octet_next[7:0];
							digit_seen_d  = 1'b1;
						end else if (octet_index_q == LAST_OCTET ||
							char_in == CHAR_COMMA || char_in == CHAR_PERIOD) begin
							// close the octet and shift it into the address
							addr_fail_d   = close_fail;
							addr_word_d   = {addr_word_q[23:0], octet_value_q};
							octet_value_d = '0;
							too_big_d     = 1'b0;
							digit_seen_d  = 1'b0;
							if (octet_index_q == LAST_OCTET)
								addr_done_d = ~close_fail;
							else
								octet_index_d = octet_index_q + 2'd1;
						end else begin
							addr_fail_d = 1'b1;
						end
					end
					if (char_in == CHAR_COMMA) begin
						comma_count_d = comma_inc;
						if (comma_inc >= ADDR_COMMAS)
							phase_d = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (digit)
						port_high_d = high_next[7:0];
					else
						phase_d = PH_LOW;
				end
				PH_LOW: begin
					if (digit)
						port_low_d = low_next[7:0];
					else
						phase_d = PH_TAIL;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_ADDR;
			comma_count_q <= '0;
			octet_index_q <= '0;
			octet_value_q <= '0;
			too_big_q     <= 1'b0;
			digit_seen_q  <= 1'b0;
			addr_fail_q   <= 1'b0;
			addr_done_q   <= 1'b0;
			addr_word_q   <= '0;
			port_high_q   <= '0;
			port_low_q    <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			comma_count_q <= comma_count_d;
			octet_index_q <= octet_index_d;
			octet_value_q <= octet_value_d;
			too_big_q     <= too_big_d;
			digit_seen_q  <= digit_seen_d;
			addr_fail_q   <= addr_fail_d;
			addr_done_q   <= addr_done_d;
			addr_word_q   <= addr_word_d;
			port_high_q   <= port_high_d;
			port_low_q    <= port_low_d;
		end
	end

	// verdict as of the state before the end byte
	assign ok = ~addr_fail_q & addr_done_q &
		(phase_q == PH_LOW || phase_q == PH_TAIL) &
		(port_high_q != 8'h00) & (port_low_q != 8'h00);

	assign result.accepted     = ok;
	assign result.host_address = ok ? addr_word_q : 32'h0;
	assign result.port_number  = ok ? {port_high_q, port_low_q} : 16'h0;

endmodule

`default_nettype wire

// ===== rtl/core/ftp_port_argument_parser.sv =====
// ftp port argument parser
//
// input channel: one argument character per word on arg_byte, with
// in_valid / in_ready; a zero byte ends the argument
// output channel: one word per argument, given when the end byte is
// processed: accepted, host_address (first octet in the top byte) and
// port_number (high byte * 256 + low byte); address and port read zero
// when accepted is low
// path: a word is captured in the input register, the parse state
// updates from it, and the end byte loads the result register in
// that same update
// throughput: one character per cycle while no end byte waits for room in
// the result register; the update is a multiply by ten as shift-and-add plus a compare
// stall: ordinary characters drain whenever they reach the state update;
// an end byte waits in the input register while the result register is
// full and not being taken, and in_ready drops behind it
// reset: arst_n clears both registers' valid flags and returns the parse
// state to the start of the address
`default_nettype none

module ftp_port_argument_parser
	import fpap_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  arg_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             accepted,
	output logic [31:0]      host_address,
	output logic [15:0]      port_number
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic        valid_s2;
	logic        accepted_s2;
	logic [31:0] address_s2;
	logic [15:0] port_s2;

	logic    is_end_s1;
	logic    out_free;
	logic    advance_s1;
	result_t result;

	assign is_end_s1  = (byte_s1 == CHAR_END);
	assign out_free   = ~valid_s2 | out_ready;
	// only an end byte needs room in the result register
	assign advance_s1 = valid_s1 & (~is_end_s1 | out_free);
	assign in_ready   = ~valid_s1 | advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= arg_byte;
	end

	fpap_parse_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.char_in (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= advance_s1 & is_end_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && advance_s1 && is_end_s1) begin
			accepted_s2 <= result.accepted;
			address_s2  <= result.host_address;
			port_s2     <= result.port_number;
		end
	end

	assign out_valid    = valid_s2;
	assign accepted     = accepted_s2;
	assign host_address = address_s2;
	assign port_number  = port_s2;

	// an accepted result always carries two nonzero port bytes
	a_port_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && accepted_s2 |-> port_s2[15:8] != 8'h00 && port_s2[7:0] != 8'h00)
		else $error("accepted result with a zero port byte");

	// a rejected result carries zero address and port
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !accepted_s2 |-> address_s2 == 32'h0 && port_s2 == 16'h0)
		else $error("rejected result with nonzero payload");

	// ordinary characters never stall in the input register
	a_char_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_end_s1 |-> in_ready)
		else $error("non-end character held in input register");

	// an end byte that moves on produces a result word in the next cycle
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && is_end_s1 |=> valid_s2)
		else $error("end byte processed without a result");

endmodule

`default_nettype wire

// ===== dv/ftp_port_checker.sv =====
`timescale 1ns / 100ps

module ftp_port_checker
	import fpap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  arg_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        accepted,
	input  logic [31:0] host_address,
	input  logic [15:0] port_number,
	output int          mismatches,
	output int          outstanding
);

	// parse state as the block should hold it
	phase_t      phase;
	logic [2:0]  commas;
	logic [1:0]  octet_idx;
	logic [7:0]  octet_val;
	logic        octet_big;
	logic        have_digit;
	logic        addr_bad;
	logic        addr_done;
	logic [31:0] addr_acc;
	logic [7:0]  port_hi;
	logic [7:0]  port_lo;

	// finished parses not yet seen on the output
	result_t     parses[$];

	function automatic logic is_num(input logic [7:0] c);
		return c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9;
	endfunction

	function automatic int decimal_shift(input logic [7:0] acc, input logic [7:0] c);
		return int'(acc) * 10 + int'(c - CHAR_DIGIT0);
	endfunction

	task automatic clear_parse();
		phase      = PH_ADDR;
		commas     = '0;
		octet_idx  = '0;
		octet_val  = '0;
		octet_big  = 1'b0;
		have_digit = 1'b0;
		addr_bad   = 1'b0;
		addr_done  = 1'b0;
		addr_acc   = '0;
		port_hi    = '0;
		port_lo    = '0;
	endtask

	task automatic close_octet();
		if (!have_digit || octet_big)
			addr_bad = 1'b1;
		addr_acc   = {addr_acc[23:0], octet_val};
		octet_val  = '0;
		octet_big  = 1'b0;
		have_digit = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] c);
		int      v;
		result_t r;
		if (c == CHAR_END) begin
			r.accepted     = !addr_bad && addr_done && (phase == PH_LOW || phase == PH_TAIL)
				&& port_hi != 0 && port_lo != 0;
			r.host_address = r.accepted ? addr_acc : '0;
			r.port_number  = r.accepted ? {port_hi, port_lo} : '0;
			parses.push_back(r);
			clear_parse();
		end else begin
			case (phase)
				PH_ADDR: begin
					if (!addr_bad && !addr_done) begin
						if (is_num(c)) begin
							v = decimal_shift(octet_val, c);
							if (v > int'(OCTET_MAX))
								octet_big = 1'b1;
							octet_val  = 8'(v);
							have_digit = 1'b1;
						end else if (octet_idx == LAST_OCTET) begin
							close_octet();
							if (!addr_bad)
								addr_done = 1'b1;
						end else if (c == CHAR_COMMA || c == CHAR_PERIOD) begin
							close_octet();
							octet_idx = octet_idx + 2'd1;
						end else begin
							addr_bad = 1'b1;
						end
					end
					if (c == CHAR_COMMA) begin
						commas = commas + 3'd1;
						if (commas >= ADDR_COMMAS)
							phase = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (is_num(c))
						port_hi = 8'(decimal_shift(port_hi, c));
					else
						phase = PH_LOW;
				end
				PH_LOW: begin
					if (is_num(c))
						port_lo = 8'(decimal_shift(port_lo, c));
					else
						phase = PH_TAIL;
				end
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_parse();
			parses.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (parses.size() == 0) begin
					$display("%0t: unexpected result: accepted %0b address %h port %0d",
						$time, accepted, host_address, port_number);
					mismatches++;
				end else begin
					want = parses.pop_front();
					if (accepted !== want.accepted) begin
						$display("%0t: accepted expected %0b got %0b",
							$time, want.accepted, accepted);
						mismatches++;
					end
					if (host_address !== want.host_address) begin
						$display("%0t: host_address expected %h got %h",
							$time, want.host_address, host_address);
						mismatches++;
					end
					if (port_number !== want.port_number) begin
						$display("%0t: port_number expected %0d got %0d",
							$time, want.port_number, port_number);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				parse_char(arg_byte);
		end
		outstanding = parses.size();
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
	import fpap_pkg::*;
();

	// stop offering new arguments once this many words have gone in
	localparam int WORD_TARGET = 1500;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  arg_byte = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        accepted;
	logic [31:0] host_address;
	logic [15:0] port_number;

	int          mismatches;
	int          outstanding;
	int          words_sent;
	int          results_taken;
	logic        sender_quiet = 1'b0;
	logic        mid_drain_done = 1'b0;

	// characters of the argument being built, end byte not included
	logic [7:0]  arg_chars[$];

	ftp_port_argument_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.arg_byte     (arg_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.host_address (host_address),
		.port_number  (port_number)
	);

	// watches both channels, predicts every parse and counts mismatches
	ftp_port_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.arg_byte     (arg_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.host_address (host_address),
		.port_number  (port_number),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// one word on the input channel; valid stays up across back-to-back words
	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		arg_byte <= b;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// the built argument followed by its end byte
	task automatic send_arg();
		foreach (arg_chars[i])
			send_word(arg_chars[i]);
		send_word(CHAR_END);
		arg_chars.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			arg_chars.push_back(s[i]);
		send_arg();
	endtask

	// stop offering words until every parse has come out
	// first let the checker see the last end byte at a clock edge
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	// decimal digits of value with optional leading zeros; negative means no digits
	task automatic push_number(input int value, input int zeros);
		string s;
		repeat (zeros) arg_chars.push_back(CHAR_DIGIT0);
		if (value >= 0) begin
			s = $sformatf("%0d", value);
			for (int i = 0; i < s.len(); i++)
				arg_chars.push_back(s[i]);
		end
	endtask

	function automatic int draw_octet();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0:       return 0;
			1:       return 255;
			2:       return $urandom_range(256, 999);
			3:       return -1;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int draw_port_byte();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return 0;
			1:       return $urandom_range(256, 99999);
			default: return $urandom_range(1, 255);
		endcase
	endfunction

	function automatic int draw_zeros();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
	endfunction

	function automatic logic [7:0] draw_noise_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return CHAR_DIGIT0 + 8'($urandom_range(0, 9));
		else if (r == 5)
			return CHAR_COMMA;
		else if (r == 6)
			return CHAR_PERIOD;
		else
			return 8'($urandom_range(1, 255));
	endfunction

	// random argument: mostly well-formed shape with random content, now and
	// then truncated; the rest noise and short junk
	task automatic build_random_arg();
		int         kind;
		int         commas_out;
		int         cut;
		int         n;
		logic [7:0] sep;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			commas_out = 0;
			for (int k = 0; k < 4; k++) begin
				push_number(draw_octet(), draw_zeros());
				if (k < 3) begin
					sep = $urandom_range(0, 1) ? CHAR_COMMA : CHAR_PERIOD;
					// now and then a bad separator
					if ($urandom_range(0, 19) == 0)
						sep = 8'($urandom_range(1, 255));
					if (sep == CHAR_COMMA)
						commas_out++;
					arg_chars.push_back(sep);
				end
			end
			// fourth octet ends at its first non-digit; junk may follow
			// until the fourth comma, and those commas still count
			while (commas_out < 4) begin
				if ($urandom_range(0, 3) == 0)
					sep = 8'($urandom_range(1, 255));
				else
					sep = CHAR_COMMA;
				if (sep == CHAR_COMMA)
					commas_out++;
				arg_chars.push_back(sep);
			end
			push_number(draw_port_byte(), draw_zeros());
			// separator between port bytes can be any byte
			if ($urandom_range(0, 2) == 0)
				arg_chars.push_back(8'($urandom_range(1, 255)));
			else
				arg_chars.push_back(CHAR_COMMA);
			push_number(draw_port_byte(), draw_zeros());
			// ignored tail
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) arg_chars.push_back(8'($urandom_range(1, 255)));
			end
			// cut short, e.g. ending right after the high port digits
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(0, arg_chars.size() - 1);
				while (arg_chars.size() > cut)
					void'(arg_chars.pop_back());
			end
		end else if (kind < 9) begin
			n = $urandom_range(0, 15);
			repeat (n) arg_chars.push_back(draw_noise_char());
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) arg_chars.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty argument, octet extremes, every rejection path,
		// fourth octet cut by junk with commas counted, port wrap and tail
		send_text("");
		send_text("255,0,9,255,1,1");
		send_text("1.2.3.4x,y,z,,9,9z");
		send_text("256,1,1,1,1,1");
		send_text("1,,1,1,1,1");
		send_text("1;1,1,1,1,1");
		send_text("1,2,3");
		send_text("1,2,3,4,5");
		send_text("1,2,3,4,0,7");
		send_text("1,2,3,4,7,0");
		send_text("1,2,3,4,300,9999");
		drain();

		// random part; one pause midway lets the block run empty
		while (words_sent < WORD_TARGET) begin
			sender_quiet = ($urandom_range(0, 3) == 0);
			build_random_arg();
			send_arg();
			if (!mid_drain_done && words_sent > WORD_TARGET / 2) begin
				mid_drain_done = 1'b1;
				drain();
			end
		end
		drain();

		// let the bench idle before the verdict
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls, bursts with none, and two long hold-offs
	// so the result register fills and the input stalls behind an end byte
	initial begin : result_side
		int gap;
		wait (arst_n);
		forever begin
			if (results_taken == 25 || results_taken == 70)
				gap = 200;
			else if ((results_taken / 16) % 4 == 3)
				gap = 0;
			else
				gap = $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

endmodule
